### design/wcr_pkg.sv
// shared types, constants and the output range function for window_convolution_rgb
// used by wcr_cfg, wcr_lane and the top level; depends on nothing else
package wcr_pkg;

    localparam int WINDOW_RADIUS = 1;
    localparam int WIN_SIDE      = 2 * WINDOW_RADIUS + 1;
    localparam int TAP_CNT       = WIN_SIDE * WIN_SIDE;
    localparam int TAP_W         = $clog2(TAP_CNT + 1);

    localparam int PIX_W  = 8;
    localparam int COEF_W = 12;
    localparam int ROW_W  = WIN_SIDE * COEF_W;
    localparam int ACC_W  = 17;
    localparam int OUT_W  = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = ROW_W;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ROW_TOP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_MID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BOT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP   = 2'd3;

    localparam int ACC_MAX = 2 ** (ACC_W - 1) - 1;
    localparam int ACC_MIN = -(2 ** (ACC_W - 1));
    localparam int OUT_MAX = 2 ** (OUT_W - 1) - 1;
    localparam int OUT_MIN = -(2 ** (OUT_W - 1));
    localparam int PIX_MAX = 255;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [OUT_W-1:0]  t_out;

    // control shared by the three channel lanes
    typedef struct packed {
        logic en;
        logic last;
        logic clamp;
    } t_lane_ctl;

    function automatic t_out finish(input t_acc v, input logic clamp);
        t_out res;
        if (clamp) begin
            if (v < t_acc'(0)) begin
                res = t_out'(0);
            end else if (v > t_acc'(PIX_MAX)) begin
                res = t_out'(PIX_MAX);
            end else begin
                res = t_out'(v);
            end
        end else begin
            if (v > t_acc'(OUT_MAX)) begin
                res = t_out'(OUT_MAX);
            end else if (v < t_acc'(OUT_MIN)) begin
                res = t_out'(OUT_MIN);
            end else begin
                res = t_out'(v);
            end
        end
        return res;
    endfunction

endpackage

### design/wcr_cfg.sv
// configuration registers and per-tap coefficient selection
// depends on wcr_pkg
module wcr_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wcr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [wcr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [wcr_pkg::TAP_W-1:0]         i_tap,
    output wcr_pkg::t_coef                    o_coef,
    output logic                              o_clamp
);

    logic [wcr_pkg::ROW_W-1:0] r_row_top;
    logic [wcr_pkg::ROW_W-1:0] r_row_mid;
    logic [wcr_pkg::ROW_W-1:0] r_row_bot;
    logic                      r_clamp;
    logic [wcr_pkg::TAP_CNT*wcr_pkg::COEF_W-1:0] coef_flat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_top <= '0;
            r_row_mid <= '0;
            r_row_bot <= '0;
            r_clamp   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wcr_pkg::REG_ROW_TOP: r_row_top <= i_cfg_data;
                wcr_pkg::REG_ROW_MID: r_row_mid <= i_cfg_data;
                wcr_pkg::REG_ROW_BOT: r_row_bot <= i_cfg_data;
                wcr_pkg::REG_CLAMP:   r_clamp   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // taps in row-major order, tap 0 lowest
    assign coef_flat = {r_row_bot, r_row_mid, r_row_top};
    assign o_coef    = coef_flat[i_tap * wcr_pkg::COEF_W +: wcr_pkg::COEF_W];
    assign o_clamp   = r_clamp;

endmodule

### design/wcr_lane.sv
// one color channel: multiply-accumulate with truncation toward zero and
// accumulator saturation; depends on wcr_pkg
module wcr_lane #(
    parameter int COEF_FRAC_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wcr_pkg::t_lane_ctl            i_ctl,
    input  logic [wcr_pkg::PIX_W-1:0]     i_pix,
    input  wcr_pkg::t_coef                i_coef,
    output wcr_pkg::t_out                 o_fin
);

    localparam int PROD_W = wcr_pkg::PIX_W + 1 + wcr_pkg::COEF_W;
    localparam int SHF_W  = wcr_pkg::ACC_W + COEF_FRAC_BITS;
    localparam int SUM_W  = ((SHF_W > PROD_W) ? SHF_W : PROD_W) + 1;
    localparam int Q_W    = SUM_W - COEF_FRAC_BITS;
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(wcr_pkg::ACC_MAX);
    localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(wcr_pkg::ACC_MIN);

    wcr_pkg::t_acc            r_acc;
    wcr_pkg::t_acc            n_acc;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  sum;
    logic signed [Q_W-1:0]    quot;

    assign prod = $signed({1'b0, i_pix}) * i_coef;
    assign sum  = (SUM_W'(r_acc) <<< COEF_FRAC_BITS) + SUM_W'(prod);

    generate
        if (COEF_FRAC_BITS == 0) begin : g_no_frac
            assign quot = sum;
        end else begin : g_frac
            logic signed [Q_W-1:0] q_floor;
            logic                  bump;
            assign q_floor = sum[SUM_W-1:COEF_FRAC_BITS];
            // negative with a fraction left: step up toward zero
            assign bump    = sum[SUM_W-1] & (|sum[COEF_FRAC_BITS-1:0]);
            assign quot    = q_floor + Q_W'(bump);
        end
    endgenerate

    always_comb begin
        if (quot > Q_MAX) begin
            n_acc = wcr_pkg::t_acc'(wcr_pkg::ACC_MAX);
        end else if (quot < Q_MIN) begin
            n_acc = wcr_pkg::t_acc'(wcr_pkg::ACC_MIN);
        end else begin
            n_acc = wcr_pkg::ACC_W'(quot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.en) begin
            r_acc <= i_ctl.last ? '0 : n_acc;
        end
    end

    assign o_fin = wcr_pkg::finish(n_acc, i_ctl.clamp);

endmodule

### design/window_convolution_rgb.sv
// 3x3 RGB window convolution, top level
// depends on wcr_pkg, wcr_cfg and wcr_lane
//
// Pixels of one 3x3 window arrive one per request in row-major order; each
// channel is weighted by a signed Q4.8 coefficient and accumulated with
// truncation toward zero after every tap. A request is taken every cycle
// unless input stall is raised; the ninth pixel of a window yields one result
// whose fields pass the input register and then the output register. The
// rate is set by the accumulator loop, one multiply-add per channel per cycle
// while the input register advances. Input stall rises only when a finished
// window is ready to leave the input register while the output register still
// holds an unclaimed result. Configuration must be written by the user while
// the block is idle, not enforced by it; coefficients apply to later taps.
module window_convolution_rgb #(
    parameter int COEF_FRAC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wcr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [wcr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [wcr_pkg::PIX_W-1:0]         i_pix_red,
    input  logic [wcr_pkg::PIX_W-1:0]         i_pix_green,
    input  logic [wcr_pkg::PIX_W-1:0]         i_pix_blue,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [wcr_pkg::OUT_W-1:0]  o_out_red,
    output logic signed [wcr_pkg::OUT_W-1:0]  o_out_green,
    output logic signed [wcr_pkg::OUT_W-1:0]  o_out_blue
);

    logic [wcr_pkg::TAP_W-1:0] r_tap;
    logic                      r_s1_vld;
    logic                      r_s1_last;
    wcr_pkg::t_coef            r_s1_coef;
    logic [wcr_pkg::PIX_W-1:0] r_s1_red;
    logic [wcr_pkg::PIX_W-1:0] r_s1_green;
    logic [wcr_pkg::PIX_W-1:0] r_s1_blue;
    logic                      r_out_vld;
    wcr_pkg::t_out             r_out_red;
    wcr_pkg::t_out             r_out_green;
    wcr_pkg::t_out             r_out_blue;

    wcr_pkg::t_coef     sel_coef;
    logic               clamp;
    logic               s1_adv;
    logic               in_acc;
    logic               tap_last;
    wcr_pkg::t_lane_ctl lane_ctl;
    wcr_pkg::t_out      fin_red;
    wcr_pkg::t_out      fin_green;
    wcr_pkg::t_out      fin_blue;

    wcr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_tap      (r_tap),
        .o_coef     (sel_coef),
        .o_clamp    (clamp)
    );

    // the last tap may only move on when the output register can take it
    assign s1_adv     = r_s1_vld & ~(r_s1_last & r_out_vld & i_out_stall);
    assign o_in_stall = r_s1_vld & ~s1_adv;
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign tap_last   = (r_tap == wcr_pkg::TAP_W'(wcr_pkg::TAP_CNT - 1));

    assign lane_ctl.en    = s1_adv;
    assign lane_ctl.last  = r_s1_last;
    assign lane_ctl.clamp = clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap    <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_tap <= tap_last ? '0 : r_tap + wcr_pkg::TAP_W'(1);
            end
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_last  <= tap_last;
            r_s1_coef  <= sel_coef;
            r_s1_red   <= i_pix_red;
            r_s1_green <= i_pix_green;
            r_s1_blue  <= i_pix_blue;
        end
    end

    wcr_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lane_ctl),
        .i_pix   (r_s1_red),
        .i_coef  (r_s1_coef),
        .o_fin   (fin_red)
    );

    wcr_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_green (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lane_ctl),
        .i_pix   (r_s1_green),
        .i_coef  (r_s1_coef),
        .o_fin   (fin_green)
    );

    wcr_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_blue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lane_ctl),
        .i_pix   (r_s1_blue),
        .i_coef  (r_s1_coef),
        .o_fin   (fin_blue)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv & r_s1_last) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv & r_s1_last) begin
            r_out_red   <= fin_red;
            r_out_green <= fin_green;
            r_out_blue  <= fin_blue;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;

endmodule
